// ----- sv/indexed_sequence_store_defines.svh -----
// Assertion macros used by the checker file
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ISS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ISS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/iss_pkg.sv -----
// Package: command codes, status codes, payload structs and controller types
package iss_pkg;

    typedef enum logic [3:0] {
        KIND_INS_FRONT = 4'd0,
        KIND_INS_BACK  = 4'd1,
        KIND_INS_AT    = 4'd2,
        KIND_REM_FRONT = 4'd3,
        KIND_REM_BACK  = 4'd4,
        KIND_REM_AT    = 4'd5,
        KIND_SEARCH    = 4'd6,
        KIND_DEDUP     = 4'd7,
        KIND_DUMP      = 4'd8,
        KIND_DUMP_REV  = 4'd9
    } kind_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] value;
        logic [5:0]         position;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] element;
        logic               last;
        logic [5:0]         count;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_SCAN,
        S_DUMP,
        S_DONE
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word, reset pointers
        logic shift;     // one step of the shift / scan sequence
        logic commit;    // finish a modifying command
        logic emit;      // load output register
        logic emit_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       out_busy;
        logic       step_done;  // pointer has reached the end of the sweep
        logic [3:0] kind;
        logic [1:0] check;      // precondition status
    } dp_stat_t;

endpackage

// ----- sv/iss_datapath.sv -----
// Datapath: cell store, pointers, command checks and output register
module iss_datapath #(
    parameter int DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  iss_pkg::in_word_t s_word,
    input  iss_pkg::dp_cmd_t  cmd,
    output iss_pkg::dp_stat_t stat,
    input  logic              m_ready,
    output logic              m_valid,
    output iss_pkg::out_word_t m_word
);
    import iss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_reg;

    in_word_t   cmd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rp_reg, rp_next;   // read pointer
    logic [CW-1:0] wp_reg, wp_next;   // write pointer
    logic       seen_reg, seen_next, found_reg, found_next;
    logic       rd_ok_reg;            // rd_reg holds a cell read since the last load
    logic [1:0] check;
    logic       m_valid_reg;
    out_word_t  m_word_reg;

    logic [CW-1:0] pos_w, tgt;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [31:0] wr_data;
    logic        pos_big;
    logic        step_done;

    kind_t kind;
    assign kind = kind_t'(cmd_reg.kind);
    assign pos_big = (32'(cmd_reg.position) > 32'(DEPTH));
    assign pos_w = pos_big ? CW'(DEPTH) : CW'(cmd_reg.position);

    always_comb begin
        check = ST_OK;
        case (kind)
            KIND_INS_FRONT, KIND_INS_BACK:
                if (count_reg >= CW'(DEPTH)) check = ST_FULL;
            KIND_INS_AT:
                if (pos_big || pos_w > count_reg) check = ST_INDEX;
                else if (count_reg >= CW'(DEPTH)) check = ST_FULL;
            KIND_REM_FRONT, KIND_REM_BACK:
                if (count_reg == '0) check = ST_EMPTY;
            KIND_REM_AT:
                if (count_reg == '0) check = ST_EMPTY;
                else if (pos_big || pos_w >= count_reg) check = ST_INDEX;
            KIND_DUMP, KIND_DUMP_REV:
                if (count_reg == '0) check = ST_EMPTY;
            default: check = ST_OK;
        endcase
    end

    // insert target index and remove target index
    always_comb begin
        case (kind)
            KIND_INS_FRONT, KIND_REM_FRONT: tgt = '0;
            KIND_INS_BACK:                  tgt = count_reg;
            KIND_REM_BACK:                  tgt = count_reg - CW'(1);
            default:                        tgt = pos_w;
        endcase
    end

    logic is_ins, is_rem;
    assign is_ins = (kind == KIND_INS_FRONT) || (kind == KIND_INS_BACK) ||
                    (kind == KIND_INS_AT);
    assign is_rem = (kind == KIND_REM_FRONT) || (kind == KIND_REM_BACK) ||
                    (kind == KIND_REM_AT);

    // Sweep schedule (one cell per cycle unless a dump is stalled by the output, read registered):
    // insert: wp walks down from count, rp one below; cell[wp] <= cell[wp-1], value at tgt on commit.
    // remove/dedup: rp walks up, wp writes compacted cells.
    // search/dump: rp walks, rd_reg gives element.
    always_comb begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        seen_next  = seen_reg;
        found_next = found_reg;
        count_next = count_reg;
        wr_en   = 1'b0;
        wr_addr = wp_reg[AW-1:0];
        wr_data = rd_reg;
        rd_addr = rp_reg[AW-1:0];
        if (cmd.load) begin
            rp_next = '0; wp_next = '0; seen_next = 1'b0; found_next = 1'b0;
        end else if (cmd.shift) begin
            if (is_ins) begin
                // wp is the cell being written, rp = wp-1 read one step earlier
                if (!rd_ok_reg) begin
                    wp_next = count_reg;
                    rp_next = count_reg - CW'(1);
                    rd_addr = AW'(count_reg - CW'(1));
                end else if (wp_reg == tgt) begin
                    wr_en = 1'b1; wr_addr = tgt[AW-1:0]; wr_data = cmd_reg.value;
                end else begin
                    wr_en = 1'b1; wr_addr = wp_reg[AW-1:0];
                    wp_next = wp_reg - CW'(1);
                    rp_next = rp_reg - CW'(1);
                    rd_addr = rp_reg[AW-1:0] - AW'(1);
                end
            end else if (is_rem) begin
                if (!rd_ok_reg) begin
                    wp_next = tgt;
                    rp_next = tgt + CW'(1);
                    rd_addr = AW'(tgt + CW'(1));
                end else if (rp_reg < count_reg) begin
                    wr_en = 1'b1;
                    wp_next = wp_reg + CW'(1);
                    rp_next = rp_reg + CW'(1);
                    rd_addr = AW'(rp_reg + CW'(1));
                end
            end else begin
                // search / dedup / dump: rp is next cell index, rd_reg is cell rp-1 (mirrored for reverse dump)
                if (rd_ok_reg) begin
                    if (kind == KIND_SEARCH && rd_reg == cmd_reg.value) found_next = 1'b1;
                    if (kind == KIND_DEDUP) begin
                        if (!(rd_reg == cmd_reg.value && seen_reg)) begin
                            wr_en = 1'b1;
                            wp_next = wp_reg + CW'(1);
                        end
                        if (rd_reg == cmd_reg.value) seen_next = 1'b1;
                    end
                end
                if (kind == KIND_DUMP_REV)
                    rd_addr = AW'(count_reg - CW'(1) - rp_reg);
                rp_next = rp_reg + CW'(1);
            end
        end
        if (cmd.commit) begin
            if (is_ins) begin
                count_next = count_reg + CW'(1);
                wr_en   = 1'b1;
                wr_addr = tgt[AW-1:0];
                wr_data = cmd_reg.value;
            end else if (is_rem) count_next = count_reg - CW'(1);
            else if (kind == KIND_DEDUP) count_next = wp_reg;
        end
    end

    // step_done: sweep finished
    always_comb begin
        if (is_ins)
            step_done = rd_ok_reg && (wp_reg == tgt);
        else if (is_rem)
            step_done = rd_ok_reg && (rp_reg >= count_reg);
        else if (kind == KIND_DUMP || kind == KIND_DUMP_REV)
            step_done = rd_ok_reg && (rp_reg >= count_reg);
        else
            step_done = rd_ok_reg && (rp_reg > count_reg);
    end
    assign stat = '{out_busy:  m_valid_reg && !m_ready,
                    step_done: step_done,
                    kind:      cmd_reg.kind,
                    check:     check};

    // rd_reg only moves on a sweep step, so a stalled dump keeps its cell
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.shift) rd_reg <= mem[rd_addr];
        if (cmd.load) cmd_reg <= s_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rp_reg      <= '0;
            wp_reg      <= '0;
            seen_reg    <= 1'b0;
            found_reg   <= 1'b0;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            seen_reg  <= seen_next;
            found_reg <= found_next;
            if (cmd.load) rd_ok_reg <= 1'b0;
            else if (cmd.shift) rd_ok_reg <= 1'b1;
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // dumps emit during the sweep; other commands and refused dumps emit once, with the commit or from S_DONE
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_word_reg.status  <= (kind == KIND_DUMP || kind == KIND_DUMP_REV) ?
                                  check : (is_ins || is_rem) ? check : ST_OK;
            m_word_reg.found   <= (kind == KIND_SEARCH) ? found_reg : 1'b0;
            m_word_reg.element <= ((kind == KIND_DUMP || kind == KIND_DUMP_REV) &&
                                   check == ST_OK) ? rd_reg : '0;
            m_word_reg.last    <= cmd.emit_last;
            m_word_reg.count   <= 6'(count_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
endmodule

// ----- sv/iss_controller.sv -----
// Controller: command sequencing state machine
module iss_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  iss_pkg::dp_stat_t stat,
    output iss_pkg::dp_cmd_t  cmd
);
    import iss_pkg::*;

    ctl_state_t state_reg, state_next;
    kind_t      k;
    logic       is_dump, is_scan;

    assign k       = kind_t'(stat.kind);
    assign is_dump = (k == KIND_DUMP) || (k == KIND_DUMP_REV);
    assign is_scan = (k == KIND_SEARCH) || (k == KIND_DEDUP);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.check != ST_OK) state_next = S_DONE;
                else if (is_dump) begin
                    cmd.shift  = 1'b1;      // prime first read
                    state_next = S_DUMP;
                end else if (is_scan) state_next = S_SCAN;
                else if (k <= KIND_REM_AT) state_next = S_SHIFT;
                else state_next = S_DONE;
            end
            S_SHIFT, S_SCAN: begin
                if (stat.step_done) begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                    if (stat.out_busy) state_next = state_reg;
                    else begin
                        cmd.emit = 1'b1; cmd.emit_last = 1'b1; state_next = S_IDLE;
                    end
                    if (stat.out_busy) cmd.commit = 1'b0;
                end else cmd.shift = 1'b1;
            end
            S_DUMP: begin
                if (!stat.out_busy) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = stat.step_done;
                    if (stat.step_done) state_next = S_IDLE;
                    else cmd.shift = 1'b1;
                end
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.emit = 1'b1; cmd.emit_last = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ----- sv/indexed_sequence_store.sv -----
// Top level: ordered store of signed words with indexed insert and remove
//   channel | direction | handshake         | word
//   s_      | in        | s_valid/s_ready   | kind, value, position
//   m_      | out       | m_valid/m_ready   | status, found, element, last, count
// A command is taken only in S_IDLE, so one finishes before the next is accepted. A
// refused command goes through S_DECIDE and S_DONE; inserts and removes sweep the cells
// they move, search and dedup sweep the whole store, and dumps emit one word per cell.
// Reset empties the store at once; no clearing pass. A stalled m_ready holds
// a dump sweep, or the commit of other commands, until the output register is free.
module indexed_sequence_store #(
    parameter int DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  iss_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output iss_pkg::out_word_t m_word
);
    import iss_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    iss_controller u_ctl (
        .aclk, .aresetn, .s_valid, .s_ready, .stat, .cmd
    );

    iss_datapath #(.DEPTH(DEPTH)) u_dp (
        .aclk, .aresetn, .s_word, .cmd, .stat, .m_ready, .m_valid, .m_word
    );
endmodule

// ----- sv/iss_checker.sv -----
// Port-level checker for the store, bound to the top level
`include "indexed_sequence_store_defines.svh"
module iss_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input iss_pkg::in_word_t  s_word,
    input logic               m_valid,
    input logic               m_ready,
    input iss_pkg::out_word_t m_word
);
    import iss_pkg::*;

    `ISS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word), "result word dropped while stalled")
    `ISS_ASSERT_SAME(a_cnt, aclk, aresetn, m_valid, m_word.count <= 6'd32 || m_word.count > 6'd32, "count undefined")
    `ISS_ASSERT_SAME(a_nready, aclk, aresetn, m_valid && !m_word.last, !s_ready, "new command taken mid dump")
    `ISS_ASSERT_NEXT(a_acc, aclk, aresetn, s_valid && s_ready, !s_ready, "two commands taken back to back")
endmodule

bind indexed_sequence_store iss_checker u_iss_checker (.*);
